// File: sv/pbld_pkg.sv
// shared constants, types and helper functions for the bitplane line decoder
package pbld_pkg;

  localparam int LINE_BYTES = 160;
  localparam int POS_W      = $clog2(LINE_BYTES + 1);
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int GRP_W      = 6;
  localparam int RUN_W      = 8;
  localparam int SUM_W      = POS_W + 2;

  // register indexes on the config port
  localparam logic [0:0] REG_RESOLUTION = 1'b0;
  localparam logic [0:0] REG_COMPRESSED = 1'b1;

  // resolution codes
  localparam logic [1:0] RES_4PLANE = 2'd0;
  localparam logic [1:0] RES_2PLANE = 2'd1;

  typedef logic [3:0][15:0] plane_words_t;

  // line format derived from the resolution register
  typedef struct packed {
    logic [2:0]       set_last;  // bytes per word set minus one
    logic [POS_W-1:0] line_len;
    logic [GRP_W-1:0] grp_last;
    logic [POS_W-1:0] stride;    // distance between plane words in a packed line
    logic [1:0]       shift;     // log2 of the word set size
  } line_fmt_t;

  function automatic line_fmt_t fmt_of(input logic [1:0] res);
    line_fmt_t f;
    case (res)
      RES_4PLANE: begin
        f.set_last = 3'd7;
        f.line_len = POS_W'(LINE_BYTES);
        f.grp_last = GRP_W'(LINE_BYTES / 8 - 1);
        f.stride   = POS_W'(LINE_BYTES / 4);
        f.shift    = 2'd3;
      end
      RES_2PLANE: begin
        f.set_last = 3'd3;
        f.line_len = POS_W'(LINE_BYTES);
        f.grp_last = GRP_W'(LINE_BYTES / 4 - 1);
        f.stride   = POS_W'(LINE_BYTES / 2);
        f.shift    = 2'd2;
      end
      default: begin
        f.set_last = 3'd1;
        f.line_len = POS_W'(LINE_BYTES / 2);
        f.grp_last = GRP_W'(LINE_BYTES / 4 - 1);
        f.stride   = POS_W'(LINE_BYTES / 2);
        f.shift    = 2'd1;
      end
    endcase
    return f;
  endfunction

  // pixel j takes bit 15-j of each plane word, plane p gives index bit p
  function automatic logic [63:0] chunky(input plane_words_t w);
    logic [63:0] px;
    px = '0;
    for (int j = 0; j < 16; j++) begin
      for (int p = 0; p < 4; p++) begin
        px[4*j+p] = w[p][15-j];
      end
    end
    return px;
  endfunction

endpackage

// File: sv/packbits_bitplane_line_decoder_top.sv
// bitplane scan-line decoder with packbits expansion, single-port line store
//
// usage:
//  - in_* carries one image byte per request (in_tdata[7:0]); out_* carries
//    one group of 16 4-bit pixel indices per request
//  - cfg_we/cfg_index/cfg_data write resolution (index 0) or compressed (index 1);
//    a write restarts the current line and is to be done while idle by the user (unchecked)
//  - uncompressed: a byte is taken with no stall; the byte that completes a
//    word set of 2*planes bytes keeps in_tready low while the set is read back from
//    the line store one byte a cycle and the group is loaded into the output register
//  - compressed: a header or literal byte is taken with no stall, a repeat run of
//    k bytes keeps in_tready low while it is written (one store write per cycle);
//    the byte that fills the line starts emission of all groups, each read back
//    in turn (20 groups at 4 planes, 40 groups at 2 or 1 planes)
//  - the single store port sets these rates: every byte goes in and out
//    of the line store through it, and one address adder walks the planes
//  - an overflowing run sends one result with out_tuser[0] high and zero
//    data; later bytes are taken and dropped until reset
//  - out_* is a registered stage: a stalled receiver holds the result and the
//    sequencer waits before loading the next group, input stays stalled
//  - reset (rst_n low at a clock edge) clears line state, error and config
module packbits_bitplane_line_decoder_top
  import pbld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] pixel_group, [69:64] group_index, [71:70] zero
  output logic        out_tlast,  // last_in_line
  output logic [0:0]  out_tuser   // [0] decode_error
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FILL   = 3'd1;
  localparam logic [2:0] S_GATHER = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  // packbits parse phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_REPEAT  = 2'd2;

  // config and line state
  logic [1:0]       res_r, res_nxt;
  logic             comp_r, comp_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic             err_seen_r, err_seen_nxt;
  logic             err_pend_r, err_pend_nxt;
  logic [7:0]       fill_r, fill_nxt;

  // group gather sequencer
  logic [2:0]       state_r, state_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic [POS_W-1:0] base_r, base_nxt;
  logic [2:0]       bc_r, bc_nxt;
  logic             multi_r, multi_nxt;

  // line store and read-back path
  logic [7:0]        line_mem [LINE_BYTES];
  logic [7:0]        mem_q_r;
  logic              mem_we;
  logic [7:0]        mem_wd;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_valid_r;
  logic [2:0]        rd_bi_r;
  plane_words_t      words_r;
  logic              clr_words;

  // output stage
  logic              out_load;
  logic              out_valid_r;
  logic [63:0]       out_pix_r;
  logic [GRP_W-1:0]  out_grp_r;
  logic              out_last_r;
  logic              out_err_r;

  line_fmt_t         fmt;
  logic [POS_W-1:0]  pos_inc;
  logic              set_done;
  logic [GRP_W-1:0]  g_unc;
  logic [POS_W-1:0]  base_unc;
  logic [8:0]        run_cnt;
  logic              overflow;
  logic [POS_W-1:0]  step;
  logic [GRP_W-1:0]  grp_inc;

  assign fmt      = fmt_of(res_r);
  assign pos_inc  = pos_r + POS_W'(1);
  assign set_done = (pos_inc[2:0] & fmt.set_last) == 3'd0;
  assign g_unc    = GRP_W'(pos_r >> fmt.shift);
  assign base_unc = pos_r - POS_W'(fmt.set_last);
  // header n below 128: n+1 literals, else 257-n repeats
  assign run_cnt  = in_tdata[7] ? (9'd257 - {1'b0, in_tdata}) : ({1'b0, in_tdata} + 9'd1);
  assign overflow = ({2'b00, pos_r} + SUM_W'(run_cnt)) > {2'b00, fmt.line_len};
  // the shared adder walks the plane words: interleaved sets step 2, packed lines step a plane
  assign step     = comp_r ? fmt.stride : POS_W'(2);
  assign grp_inc  = grp_r + GRP_W'(1);
  assign rd_addr  = ADDR_W'({base_r[POS_W-1:1], bc_r[0]});
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    res_nxt      = res_r;
    comp_nxt     = comp_r;
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    run_nxt      = run_r;
    err_seen_nxt = err_seen_r;
    err_pend_nxt = err_pend_r;
    fill_nxt     = fill_r;
    state_nxt    = state_r;
    grp_nxt      = grp_r;
    base_nxt     = base_r;
    bc_nxt       = bc_r;
    multi_nxt    = multi_r;
    mem_we       = 1'b0;
    mem_wd       = in_tdata;
    rd_en        = 1'b0;
    clr_words    = 1'b0;
    out_load     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && !err_seen_r) begin
          if (!comp_r) begin
            mem_we  = 1'b1;
            pos_nxt = (pos_inc >= fmt.line_len) ? '0 : pos_inc;
            if (set_done) begin
              grp_nxt   = g_unc;
              base_nxt  = base_unc;
              bc_nxt    = '0;
              multi_nxt = 1'b0;
              clr_words = 1'b1;
              state_nxt = S_GATHER;
            end
          end else begin
            case (phase_r)
              PH_HEADER: begin
                if (overflow) begin
                  err_seen_nxt = 1'b1;
                  err_pend_nxt = 1'b1;
                  state_nxt    = S_OUT;
                end else begin
                  run_nxt   = run_cnt[RUN_W-1:0];
                  phase_nxt = in_tdata[7] ? PH_REPEAT : PH_LITERAL;
                end
              end
              PH_LITERAL: begin
                mem_we  = 1'b1;
                pos_nxt = pos_inc;
                run_nxt = run_r - RUN_W'(1);
                if (run_r <= RUN_W'(1)) begin
                  phase_nxt = PH_HEADER;
                end
                if (pos_inc >= fmt.line_len) begin
                  pos_nxt   = '0;
                  phase_nxt = PH_HEADER;
                  run_nxt   = '0;
                  grp_nxt   = '0;
                  base_nxt  = '0;
                  bc_nxt    = '0;
                  multi_nxt = 1'b1;
                  clr_words = 1'b1;
                  state_nxt = S_GATHER;
                end
              end
              default: begin
                fill_nxt  = in_tdata;
                state_nxt = S_FILL;
              end
            endcase
          end
        end
      end
      S_FILL: begin
        mem_we  = 1'b1;
        mem_wd  = fill_r;
        pos_nxt = pos_inc;
        run_nxt = run_r - RUN_W'(1);
        if (run_r <= RUN_W'(1)) begin
          phase_nxt = PH_HEADER;
          state_nxt = S_IDLE;
          if (pos_inc >= fmt.line_len) begin
            pos_nxt   = '0;
            run_nxt   = '0;
            grp_nxt   = '0;
            base_nxt  = '0;
            bc_nxt    = '0;
            multi_nxt = 1'b1;
            clr_words = 1'b1;
            state_nxt = S_GATHER;
          end
        end
      end
      S_GATHER: begin
        rd_en  = 1'b1;
        bc_nxt = bc_r + 3'd1;
        if (bc_r[0]) begin
          base_nxt = base_r + step;
        end
        if (bc_r == fmt.set_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          if (err_pend_r) begin
            err_pend_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end else if (multi_r && grp_r != fmt.grp_last) begin
            grp_nxt   = grp_inc;
            base_nxt  = POS_W'({grp_inc, 1'b0});
            bc_nxt    = '0;
            clr_words = 1'b1;
            state_nxt = S_GATHER;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // config writes restart the line, the error stays
    if (cfg_we) begin
      case (cfg_index)
        REG_RESOLUTION: begin
          res_nxt   = cfg_data;
          pos_nxt   = '0;
          phase_nxt = PH_HEADER;
          run_nxt   = '0;
        end
        REG_COMPRESSED: begin
          comp_nxt  = cfg_data[0];
          pos_nxt   = '0;
          phase_nxt = PH_HEADER;
          run_nxt   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r      <= RES_4PLANE;
      comp_r     <= 1'b0;
      pos_r      <= '0;
      phase_r    <= PH_HEADER;
      run_r      <= '0;
      err_seen_r <= 1'b0;
      err_pend_r <= 1'b0;
      state_r    <= S_IDLE;
      grp_r      <= '0;
      base_r     <= '0;
      bc_r       <= '0;
      multi_r    <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      res_r      <= res_nxt;
      comp_r     <= comp_nxt;
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      run_r      <= run_nxt;
      err_seen_r <= err_seen_nxt;
      err_pend_r <= err_pend_nxt;
      state_r    <= state_nxt;
      grp_r      <= grp_nxt;
      base_r     <= base_nxt;
      bc_r       <= bc_nxt;
      multi_r    <= multi_nxt;
      rd_valid_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    fill_r  <= fill_nxt;
    rd_bi_r <= bc_r;
  end

  // line store, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[pos_r[ADDR_W-1:0]] <= mem_wd;
    end
    if (rd_en) begin
      mem_q_r <= line_mem[rd_addr];
    end
  end

  // even byte of a plane word is its high byte
  always_ff @(posedge clk) begin
    if (clr_words) begin
      words_r <= '0;
    end else if (rd_valid_r) begin
      if (rd_bi_r[0]) begin
        words_r[rd_bi_r[2:1]][7:0] <= mem_q_r;
      end else begin
        words_r[rd_bi_r[2:1]][15:8] <= mem_q_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r  <= err_pend_r ? 64'd0 : chunky(words_r);
      out_grp_r  <= err_pend_r ? '0 : grp_r;
      out_last_r <= !err_pend_r && (grp_r == fmt.grp_last);
      out_err_r  <= err_pend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_grp_r, out_pix_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  // an error result carries no pixels and no line end
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 72'd0 && !out_tlast)
    else $error("error result carries data");

  // the fill position never reaches the line length
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < fmt.line_len)
    else $error("line position out of range");

  // reads stay inside one word set
  a_gather_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GATHER |-> bc_r <= fmt.set_last)
    else $error("gather count past word set");

  // the error stays until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_seen_r |=> err_seen_r)
    else $error("error flag cleared");

  // no byte is taken while a group is being read back
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !in_tready && !mem_we)
    else $error("store port conflict");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the packbits bitplane line decoder
module tb_top
  import pbld_pkg::*;
();

  // resolution codes beyond the two the package names
  localparam logic [1:0] RES_1PLANE     = 2'd2;
  localparam logic [1:0] RES_1PLANE_ALT = 2'd3;  // decodes like RES_1PLANE

  localparam int CLK_HALF     = 6;
  localparam int IDLE_PCT     = 16;    // chance of an idle cycle on either side
  localparam int SETTLE_CYC   = 200;   // covers a 129-byte repeat run with no result
  localparam int STALL_LIMIT  = 5000;  // cycles with no request moving on any side
  localparam int RANDOM_ITEMS = 500;

  typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_REPEAT} run_phase_t;

  typedef struct packed {
    logic [63:0] pixels;
    logic [5:0]  group_idx;
    logic        line_end;
    logic        overflow;
  } pixel_group_t;

  // line decoder model plus the queue of pixel groups still owed by the block
  class line_scoreboard;
    pixel_group_t pending[$];
    logic [7:0]   line_mem [LINE_BYTES];
    int unsigned  fill_pos;
    int unsigned  run_left;
    run_phase_t   phase;
    bit           overflowed;
    logic [1:0]   res;
    bit           packed_mode;
    int           mismatches;

    function new();
      restart();
      overflowed  = 1'b0;
      res         = RES_4PLANE;
      packed_mode = 1'b0;
      mismatches  = 0;
    endfunction

    function int unsigned planes();
      if (res == RES_4PLANE) return 4;
      if (res == RES_2PLANE) return 2;
      return 1;
    endfunction

    function int unsigned line_len();
      return (res inside {RES_4PLANE, RES_2PLANE}) ? LINE_BYTES : LINE_BYTES / 2;
    endfunction

    function void restart();
      fill_pos = 0;
      run_left = 0;
      phase    = PH_HEADER;
    endfunction

    // any register write restarts the line, the overflow flag survives
    function void write_reg(logic [0:0] idx, logic [1:0] val);
      if (idx == REG_RESOLUTION) res = val;
      else packed_mode = val[0];
      restart();
    endfunction

    // one word per plane, pixel j from bit 15-j, plane p gives index bit p
    function void emit_group(int unsigned base, int unsigned step, int unsigned g,
                             int unsigned groups);
      logic [15:0]  words [4];
      pixel_group_t r;
      for (int p = 0; p < 4; p++) words[p] = '0;
      for (int p = 0; p < planes(); p++)
        words[p] = {line_mem[base + p * step], line_mem[base + p * step + 1]};
      r.pixels = '0;
      for (int j = 0; j < 16; j++)
        for (int p = 0; p < 4; p++)
          r.pixels[4 * j + p] = words[p][15 - j];
      r.group_idx = 6'(g);
      r.line_end  = (g + 1 == groups);
      r.overflow  = 1'b0;
      pending.push_back(r);
    endfunction

    function void note_input(logic [7:0] b);
      int unsigned  n_planes, len, set_bytes, groups, cnt;
      pixel_group_t r;
      n_planes  = planes();
      len       = line_len();
      set_bytes = 2 * n_planes;
      groups    = len / set_bytes;
      if (overflowed) return;
      if (!packed_mode) begin
        line_mem[fill_pos] = b;
        fill_pos++;
        if (fill_pos % set_bytes == 0)
          emit_group(fill_pos - set_bytes, 2, fill_pos / set_bytes - 1, groups);
        if (fill_pos >= len) fill_pos = 0;
        return;
      end
      case (phase)
        PH_HEADER: begin
          cnt = (b <= 127) ? b + 1 : 257 - b;
          if (fill_pos + cnt > len) begin
            overflowed = 1'b1;
            r          = '0;
            r.overflow = 1'b1;
            pending.push_back(r);
          end else begin
            run_left = cnt;
            phase    = (b <= 127) ? PH_LITERAL : PH_REPEAT;
          end
          return;
        end
        PH_LITERAL: begin
          line_mem[fill_pos] = b;
          fill_pos++;
          run_left--;
          if (run_left == 0) phase = PH_HEADER;
        end
        default: begin
          while (run_left > 0) begin
            line_mem[fill_pos] = b;
            fill_pos++;
            run_left--;
          end
          phase = PH_HEADER;
        end
      endcase
      // a full packed line sends all its groups, planes lie one after another
      if (fill_pos >= len) begin
        for (int unsigned g = 0; g < groups; g++)
          emit_group(2 * g, len / n_planes, g, groups);
        restart();
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check(logic [63:0] px, logic [5:0] gi, logic le, logic ov);
      pixel_group_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected group px=%h idx=%0d", px, gi));
        return;
      end
      want = pending.pop_front();
      if (px !== want.pixels)
        report($sformatf("pixels %h, want %h (group %0d)", px, want.pixels, want.group_idx));
      if (gi !== want.group_idx)
        report($sformatf("group index %0d, want %0d", gi, want.group_idx));
      if (le !== want.line_end)
        report($sformatf("line end %b, want %b (group %0d)", le, want.line_end, want.group_idx));
      if (ov !== want.overflow)
        report($sformatf("decode error %b, want %b", ov, want.overflow));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [1:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // [63:0] pixel_group, [69:64] group_index, [71:70] zero
  logic        out_tlast;  // last_in_line
  logic [0:0]  out_tuser;  // [0] decode_error

  line_scoreboard sb;
  int unsigned    bytes_sent;
  bit             calm;    // no idling on either side while set

  packbits_bitplane_line_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // run lengths lean on the ends of their range
  function automatic int unsigned pick_count(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // one byte request; entered and left at a falling edge, valid stays high
  task automatic push_byte(logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // stop sending until every owed group is back, optionally let the block settle
  task automatic wait_drained(bit settle);
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // both registers written back to back while the block is idle
  task automatic reconfigure(logic [1:0] res, bit packed_lines);
    wait_drained(1'b1);
    cfg_we    = 1'b1;
    cfg_index = REG_RESOLUTION;
    cfg_data  = res;
    @(posedge clk);
    sb.write_reg(REG_RESOLUTION, res);
    @(negedge clk);
    cfg_index = REG_COMPRESSED;
    cfg_data  = {1'b0, packed_lines};
    @(posedge clk);
    sb.write_reg(REG_COMPRESSED, {1'b0, packed_lines});
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // interleaved plane words, raw bytes
  task automatic send_plain_line(bit whole);
    int unsigned n;
    n = whole ? sb.line_len() : $urandom_range(1, sb.line_len() - 1);
    repeat (n) push_byte(8'($urandom));
  endtask

  // well-formed packbits line; a partial one may end inside a literal run
  task automatic send_packed_line(bit whole);
    int unsigned len, target, done, room, cnt;
    len    = sb.line_len();
    target = whole ? len : $urandom_range(1, len - 1);
    done   = 0;
    while (done < target) begin
      room = target - done;
      if (room >= 2 && $urandom_range(1)) begin
        cnt = pick_count(2, (room < 129) ? room : 129);
        push_byte(8'(257 - cnt));
        push_byte(8'($urandom));
      end else begin
        cnt = pick_count(1, (room < 128) ? room : 128);
        push_byte(8'(cnt - 1));
        repeat (cnt) push_byte(8'($urandom));
      end
      done += cnt;
    end
    // cut-off literal run, dropped by the line restart on the next register write
    if (!whole && $urandom_range(1)) begin
      cnt = pick_count(1, (len - done < 128) ? len - done : 128);
      push_byte(8'(cnt - 1));
      repeat ($urandom_range(0, cnt - 1)) push_byte(8'($urandom));
    end
  endtask

  // result side: ready changes at the falling edge
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_tready = calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // every accepted result request is checked against the oldest owed group
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check(out_tdata[63:0], out_tdata[69:64], out_tlast, out_tuser[0]);
  end

  // ends the run when no request moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned iter, start, kind, lines;
    sb         = new();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_RESOLUTION;
    cfg_data   = RES_4PLANE;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    calm       = 1'b0;
    bytes_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // uncompressed 4 planes: one word set with all-zero, all-one and single bits
    reconfigure(RES_4PLANE, 1'b0);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h01);
    push_byte(8'hAA);
    push_byte(8'h55);
    push_byte(8'hFF);
    push_byte(8'h00);

    // packed 1 plane: shortest literal, shortest repeat, then a repeat to the line end
    reconfigure(RES_1PLANE, 1'b1);
    push_byte(8'd0);
    push_byte(8'h5A);
    push_byte(8'd255);
    push_byte(8'hFF);
    push_byte(8'd180);
    push_byte(8'h00);

    // packed 4 planes: longest repeat run then the rest of the line
    reconfigure(RES_4PLANE, 1'b1);
    push_byte(8'd128);
    push_byte(8'hC3);
    push_byte(8'd226);
    push_byte(8'h3C);

    // the spare resolution code behaves like 1 plane: one 80-byte repeat
    reconfigure(RES_1PLANE_ALT, 1'b1);
    push_byte(8'd177);
    push_byte(8'h81);

    // uncompressed 2 planes: one word set
    reconfigure(RES_2PLANE, 1'b0);
    push_byte(8'h01);
    push_byte(8'h80);
    push_byte(8'hFE);
    push_byte(8'h7F);

    // random settings, mostly whole lines, some cut short and restarted
    iter  = 0;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      iter++;
      calm = (iter >= 4 && iter < 8);
      reconfigure(2'($urandom_range(3)), 1'($urandom_range(1)));
      kind  = $urandom_range(9);
      lines = (kind < 8) ? $urandom_range(1, 2) : 1;
      for (int l = 0; l < lines; l++) begin
        if (sb.packed_mode) send_packed_line(kind < 8);
        else send_plain_line(kind < 8);
        // sender holds off until the block has caught up
        if ($urandom_range(7) == 0) wait_drained(1'b0);
      end
    end
    calm = 1'b0;

    // overflowing run: one error result, then every byte is dropped
    reconfigure(RES_1PLANE, 1'b1);
    push_byte(8'd128);
    repeat (4) push_byte(8'($urandom));

    wait_drained(1'b1);
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
